[sv/dual_delimiter_frame_receiver_assert.svh]
// ----------------------------------------------------------------------------
// dual_delimiter_frame_receiver_assert.svh
// Assertion macros for the checker of the frame receiver.
// ----------------------------------------------------------------------------
`ifndef DUAL_DELIMITER_FRAME_RECEIVER_ASSERT_SVH
`define DUAL_DELIMITER_FRAME_RECEIVER_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while rst is high
`define DDFR_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst is high
`define DDFR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[sv/ddfr_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ddfr_pkg
// Shared constants and types of the dual delimiter frame receiver.
// ----------------------------------------------------------------------------
package ddfr_pkg;

  // Item kinds carried on the input tuser
  localparam logic [1:0] KIND_BYTE    = 2'd0;
  localparam logic [1:0] KIND_RELEASE = 2'd1;
  localparam logic [1:0] KIND_READ    = 2'd2;

  // Frame delimiters
  localparam logic [7:0] FLAG_BYTE = 8'h7E;
  localparam logic [7:0] ESC_BYTE  = 8'h1B;

  // Field widths of the result
  localparam int unsigned COUNT_W = 6;

  // Status flags after one item
  typedef struct packed {
    logic frame_ready;
    logic packet_ready;
    logic overflow;
  } ddfr_flags_t;

endpackage

[sv/ddfr_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ddfr_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module ddfr_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read, held while re is low
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[sv/ddfr_framer.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ddfr_framer
// Delimiter state machine, byte count and ready flags; issues buffer writes.
// ----------------------------------------------------------------------------
module ddfr_framer
  import ddfr_pkg::*;
#(
  parameter int unsigned BUF_DEPTH = 32
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         item_take,
  input  logic [1:0]                   kind,
  input  logic [7:0]                   rx_byte,
  input  logic                         line_error,
  output logic                         wr_en,
  output logic [$clog2(BUF_DEPTH)-1:0] wr_addr,
  output logic [7:0]                   wr_data,
  output logic [COUNT_W-1:0]           count_next_out,
  output ddfr_flags_t                  flags_next
);

  localparam int unsigned AW = $clog2(BUF_DEPTH);
  localparam int unsigned CW = $clog2(BUF_DEPTH + 1);

  // Receive modes
  localparam logic [2:0] MODE_IDLE    = 3'd0;
  localparam logic [2:0] MODE_F_START = 3'd1;
  localparam logic [2:0] MODE_F_IN    = 3'd2;
  localparam logic [2:0] MODE_P_START = 3'd3;
  localparam logic [2:0] MODE_P_IN    = 3'd4;

  logic [2:0]      rx_mode, rx_mode_next;
  logic [CW-1:0]   stored_count, stored_count_next;
  logic            frame_done, frame_done_next;
  logic            packet_done, packet_done_next;
  logic            store_req;
  logic [CW-1:0]   store_base;
  logic            store_full;
  logic            overflow;
  logic [CW+COUNT_W-1:0] count_ext;

  // Work out the state after one item
  always_comb begin
    rx_mode_next      = rx_mode;
    stored_count_next = stored_count;
    frame_done_next   = frame_done;
    packet_done_next  = packet_done;
    store_req         = 1'b0;
    store_base        = stored_count;

    if (kind == KIND_BYTE) begin
      if (line_error) begin
        frame_done_next   = 1'b0;
        stored_count_next = '0;
      end else if (!frame_done && !packet_done) begin
        unique case (rx_mode)
          MODE_F_START: begin
            if (rx_byte != FLAG_BYTE) begin
              store_req    = 1'b1;
              rx_mode_next = MODE_F_IN;
            end
          end
          MODE_F_IN: begin
            store_req = 1'b1;
            if (rx_byte == FLAG_BYTE) begin
              frame_done_next = 1'b1;
              rx_mode_next    = MODE_IDLE;
            end
          end
          MODE_P_START: begin
            if (rx_byte != ESC_BYTE) begin
              store_req    = 1'b1;
              rx_mode_next = MODE_P_IN;
            end
          end
          MODE_P_IN: begin
            if (rx_byte == ESC_BYTE) begin
              packet_done_next = 1'b1;
              rx_mode_next     = MODE_IDLE;
            end else begin
              store_req = 1'b1;
            end
          end
          default: begin
            // Idle, and any unused code behaves as idle
            if (rx_byte == FLAG_BYTE) begin
              store_base        = '0;
              stored_count_next = '0;
              store_req         = 1'b1;
              rx_mode_next      = MODE_F_START;
            end else if (rx_byte == ESC_BYTE) begin
              stored_count_next = '0;
              rx_mode_next      = MODE_P_START;
            end else begin
              rx_mode_next = MODE_IDLE;
            end
          end
        endcase
      end
    end else if (kind == KIND_RELEASE) begin
      frame_done_next  = 1'b0;
      packet_done_next = 1'b0;
    end

    // Append the byte unless the buffer is full
    store_full = (store_base == CW'(BUF_DEPTH));
    overflow   = store_req && store_full;
    wr_en      = item_take && store_req && !store_full;
    if (store_req && !store_full) begin
      stored_count_next = store_base + CW'(1);
    end
  end

  assign wr_addr = store_base[AW-1:0];
  assign wr_data = rx_byte;

  // Report the count in the result field width
  assign count_ext      = {{COUNT_W{1'b0}}, stored_count_next};
  assign count_next_out = count_ext[COUNT_W-1:0];

  assign flags_next.frame_ready  = frame_done_next;
  assign flags_next.packet_ready = packet_done_next;
  assign flags_next.overflow     = overflow;

  // Advance the state on each accepted item
  always_ff @(posedge clk) begin
    if (rst) begin
      rx_mode      <= MODE_IDLE;
      stored_count <= '0;
      frame_done   <= 1'b0;
      packet_done  <= 1'b0;
    end else if (item_take) begin
      rx_mode      <= rx_mode_next;
      stored_count <= stored_count_next;
      frame_done   <= frame_done_next;
      packet_done  <= packet_done_next;
    end
  end

endmodule

[sv/dual_delimiter_frame_receiver.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dual_delimiter_frame_receiver
// Builds 0x7E and 0x1B delimited frames from received bytes in a byte buffer.
// ----------------------------------------------------------------------------
//  Channel  Direction  Payload
//  s_       in         tuser: kind; tdata: rx_byte, line_error, read_index
//  m_       out        tdata: read_data, byte_count, frame_ready,
//                      packet_ready, overflow
//
// One item a cycle: the state update and the buffer write happen at the
// edge that accepts the item, and the result (with the buffer read from the
// registered RAM port) shows on m_ the cycle after.
// s_tready is high whenever the output register is empty or being taken,
// so a stalled m_ side stops the input only once a result is waiting.
// Reset clears the mode, count and flags; the buffer itself is not cleared.
// ----------------------------------------------------------------------------
module dual_delimiter_frame_receiver
  import ddfr_pkg::*;
#(
  parameter int unsigned BUF_DEPTH = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // rx_byte[7:0], line_error[8], read_index[13:9]
  input  logic [1:0]  s_tuser,   // kind[1:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata    // read_data[7:0], byte_count[13:8], frame_ready[14],
                                 // packet_ready[15], overflow[16]
);

  localparam int unsigned AW = $clog2(BUF_DEPTH);

  logic               item_take;
  logic [1:0]         kind;
  logic [7:0]         rx_byte;
  logic               line_error;
  logic [4:0]         read_index;
  logic               wr_en;
  logic [AW-1:0]      wr_addr;
  logic [7:0]         wr_data;
  logic [COUNT_W-1:0] count_next;
  ddfr_flags_t        flags_next;
  logic [AW+4:0]      read_index_ext;
  logic [AW-1:0]      raddr;
  logic               read_hit;
  logic [7:0]         rdata;
  logic               out_valid;
  logic [COUNT_W-1:0] out_count;
  ddfr_flags_t        out_flags;
  logic               out_read;

  // Unpack the input transfer
  assign kind       = s_tuser;
  assign rx_byte    = s_tdata[7:0];
  assign line_error = s_tdata[8];
  assign read_index = s_tdata[13:9];

  assign s_tready  = !out_valid || m_tready;
  assign item_take = s_tvalid && s_tready;

  ddfr_framer #(
    .BUF_DEPTH (BUF_DEPTH)
  ) u_framer (
    .clk            (clk),
    .rst            (rst),
    .item_take      (item_take),
    .kind           (kind),
    .rx_byte        (rx_byte),
    .line_error     (line_error),
    .wr_en          (wr_en),
    .wr_addr        (wr_addr),
    .wr_data        (wr_data),
    .count_next_out (count_next),
    .flags_next     (flags_next)
  );

  // Buffer read address and range check
  assign read_index_ext = {{AW{1'b0}}, read_index};
  assign raddr          = read_index_ext[AW-1:0];
  assign read_hit       = (kind == KIND_READ) && ({27'd0, read_index} < 32'(BUF_DEPTH));

  ddfr_ram #(
    .WIDTH (8),
    .DEPTH (BUF_DEPTH)
  ) u_buf (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (wr_data),
    .re    (item_take),
    .raddr (raddr),
    .rdata (rdata)
  );

  // Output register valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s_tready) begin
      out_valid <= s_tvalid;
    end
  end

  // Hold the result payload until the next accepted item
  always_ff @(posedge clk) begin
    if (item_take) begin
      out_count <= count_next;
      out_flags <= flags_next;
      out_read  <= read_hit;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {7'd0, out_flags.overflow, out_flags.packet_ready,
                     out_flags.frame_ready, out_count,
                     (out_read ? rdata : 8'd0)};

endmodule

[sv/ddfr_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ddfr_checker
// Port-level checks of the frame receiver, bound to the top level.
// ----------------------------------------------------------------------------
`include "dual_delimiter_frame_receiver_assert.svh"

module ddfr_checker
  import ddfr_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic [1:0]  s_tuser,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [23:0] m_tdata
);

  logic s_xfer;

  assign s_xfer = s_tvalid && s_tready;

  // A waiting result holds until taken
  `DDFR_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result changed while stalled")

  // Every accepted item yields a result in the next cycle
  `DDFR_ASSERT_NEXT(a_one_result, s_xfer, m_tvalid, "accepted item gave no result")

  // A release leaves both ready flags clear
  `DDFR_ASSERT_NEXT(a_release_clears, s_xfer && (s_tuser == KIND_RELEASE), m_tdata[15:14] == 2'b00, "release left a ready flag set")

  // Only a read returns buffer data
  `DDFR_ASSERT_NEXT(a_read_zero, s_xfer && (s_tuser != KIND_READ), m_tdata[7:0] == 8'd0, "non-read item returned data")

  // An empty output register never stalls the input
  `DDFR_ASSERT_NOW(a_ready_empty, !m_tvalid, s_tready, "input stalled with output empty")

endmodule

bind dual_delimiter_frame_receiver ddfr_checker u_ddfr_checker (.*);
